>>> src/via_pkg.sv
// ============================================================================
// via_pkg
// Shared types and codes for the versatile interface adapter.
// ============================================================================
package via_pkg;

    // Item commands
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_READ  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_LINE  = 3'd3;
    localparam logic [2:0] CMD_PORTB = 3'd4;

    // Register offsets
    localparam logic [3:0] REG_ORB  = 4'd0;
    localparam logic [3:0] REG_ORA  = 4'd1;
    localparam logic [3:0] REG_DDRB = 4'd2;
    localparam logic [3:0] REG_DDRA = 4'd3;
    localparam logic [3:0] REG_T1CL = 4'd4;
    localparam logic [3:0] REG_T1CH = 4'd5;
    localparam logic [3:0] REG_T1LL = 4'd6;
    localparam logic [3:0] REG_T1LH = 4'd7;
    localparam logic [3:0] REG_T2CL = 4'd8;
    localparam logic [3:0] REG_T2CH = 4'd9;
    localparam logic [3:0] REG_SR   = 4'd10;
    localparam logic [3:0] REG_ACR  = 4'd11;
    localparam logic [3:0] REG_PCR  = 4'd12;
    localparam logic [3:0] REG_IFR  = 4'd13;
    localparam logic [3:0] REG_IER  = 4'd14;

    // Interrupt flag bits
    localparam logic [7:0] IRQ_CA2 = 8'h01;
    localparam logic [7:0] IRQ_CA1 = 8'h02;
    localparam logic [7:0] IRQ_SR  = 8'h04;
    localparam logic [7:0] IRQ_CB2 = 8'h08;
    localparam logic [7:0] IRQ_CB1 = 8'h10;
    localparam logic [7:0] IRQ_T2  = 8'h20;
    localparam logic [7:0] IRQ_T1  = 8'h40;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] cycles;
        logic [3:0] reg_addr;
        logic [7:0] write_data;
        logic [1:0] line_select;
        logic [2:0] bit_index;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_request;
        logic       irq_pending;
        logic       ca2_level;
        logic       cb2_level;
        logic [7:0] port_a_out;
        logic [7:0] port_b_out;
        logic       port_b_written;
    } t_out_item;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LATCH,
        OP_EXEC,
        OP_TICK,
        OP_T1_STEP,
        OP_T2
    } t_op;

    typedef struct packed {
        t_op op;
    } t_ctl;

    typedef struct packed {
        logic t1_free;
        logic t1_more;
    } t_sts;

endpackage

>>> src/via_ctrl.sv
// ============================================================================
// via_ctrl
// Sequencer: latches a transaction, walks the tick phases, strobes result.
// ============================================================================
module via_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [2:0]          i_command,
    input  via_pkg::t_sts       i_sts,
    output via_pkg::t_ctl       o_ctl,
    output logic                busy,
    output logic                o_strobe
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_T1,
        S_T2,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, r_strobe;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (i_command == via_pkg::CMD_TICK) ? S_TICK : S_EXEC;
                end
            end
            S_EXEC: n_state = S_DONE;
            S_TICK: n_state = i_sts.t1_free ? S_T1 : S_T2;
            S_T1: begin
                if (!i_sts.t1_more) begin
                    n_state = S_T2;
                end
            end
            S_T2:   n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath command
    always_comb begin
        unique case (r_state)
            S_IDLE:  o_ctl.op = start ? via_pkg::OP_LATCH : via_pkg::OP_NONE;
            S_EXEC:  o_ctl.op = via_pkg::OP_EXEC;
            S_TICK:  o_ctl.op = via_pkg::OP_TICK;
            S_T1:    o_ctl.op = via_pkg::OP_T1_STEP;
            S_T2:    o_ctl.op = via_pkg::OP_T2;
            default: o_ctl.op = via_pkg::OP_NONE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= (n_state != S_IDLE);
            r_strobe <= (n_state == S_DONE);
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;

`ifndef SYNTHESIS
    // accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");
    // result strobe lasts one cycle
    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");
    // block goes idle right after the result
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !busy)
        else $error("busy after result");
    // strobe only while busy
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("strobe while idle");
`endif

endmodule

>>> src/via_dp.sv
// ============================================================================
// via_dp
// Register file, timers, control lines and interrupt logic.
// ============================================================================
module via_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  via_pkg::t_in_item   i_item,
    input  via_pkg::t_ctl       i_ctl,
    output via_pkg::t_sts       o_sts,
    output via_pkg::t_out_item  o_result
);

    via_pkg::t_in_item r_in, n_in;
    logic [7:0]  r_out_a, n_out_a, r_out_b, n_out_b;
    logic [7:0]  r_dir_a, n_dir_a, r_dir_b, n_dir_b, r_in_b, n_in_b;
    logic [15:0] r_t1_latch, n_t1_latch, r_t1_count, n_t1_count;
    logic [15:0] r_t2_latch, n_t2_latch, r_t2_count, n_t2_count;
    logic        r_t1_run, n_t1_run, r_t1_rld, n_t1_rld;
    logic        r_t2_run, n_t2_run, r_t2_rld, n_t2_rld;
    logic [7:0]  r_sr, n_sr, r_acr, n_acr, r_pcr, n_pcr, r_ifr, n_ifr;
    logic [6:0]  r_ier, n_ier;
    logic [3:0]  r_lines, n_lines;
    logic [1:0]  r_pulse, n_pulse;
    logic [7:0]  r_todo, n_todo;
    logic [7:0]  r_rd, n_rd;
    logic        r_hit, n_hit, r_wrote, n_wrote;

    // set flags, raise bit 7 when any enabled flag is set
    function automatic logic [7:0] f_set(logic [7:0] flags, logic [7:0] bits,
                                         logic [6:0] ie);
        logic [7:0] f;
        f = flags | bits;
        if (|(f[6:0] & ie)) f[7] = 1'b1;
        return f;
    endfunction

    // clear flags, drop bit 7 when no enabled flag remains
    function automatic logic [7:0] f_clr(logic [7:0] flags, logic [7:0] bits,
                                         logic [6:0] ie);
        logic [7:0] f;
        f = flags & ~bits;
        if (!(|(f[6:0] & ie))) f[7] = 1'b0;
        return f;
    endfunction

    logic        v_pa_do, v_pa_side;
    logic [2:0]  v_mode;
    logic [1:0]  v_sel;
    logic        v_lvl, v_side, v_pos_edge;
    logic [7:0]  v_t, v_t2_todo, v_mask;
    logic        v_t1_over;

    assign v_t1_over = ({8'd0, r_todo} > r_t1_count);
    assign v_t       = r_todo - r_t1_count[7:0] - 8'd1;

    assign o_sts.t1_free = r_acr[6] && (r_in.cycles != 8'd0);
    assign o_sts.t1_more = v_t1_over && (v_t != 8'd0);

    always_comb begin
        n_in = r_in;       n_out_a = r_out_a;   n_out_b = r_out_b;
        n_dir_a = r_dir_a; n_dir_b = r_dir_b;   n_in_b = r_in_b;
        n_t1_latch = r_t1_latch; n_t1_count = r_t1_count;
        n_t2_latch = r_t2_latch; n_t2_count = r_t2_count;
        n_t1_run = r_t1_run; n_t1_rld = r_t1_rld;
        n_t2_run = r_t2_run; n_t2_rld = r_t2_rld;
        n_sr = r_sr; n_acr = r_acr; n_pcr = r_pcr; n_ifr = r_ifr; n_ier = r_ier;
        n_lines = r_lines; n_pulse = r_pulse; n_todo = r_todo;
        n_rd = r_rd; n_hit = r_hit; n_wrote = r_wrote;
        v_pa_do = 1'b0; v_pa_side = 1'b0; v_mode = 3'd0; v_sel = 2'd0;
        v_lvl = r_in.write_data[0]; v_side = r_in.line_select[1];
        v_pos_edge = 1'b0; v_t2_todo = 8'd0; v_mask = 8'd0;

        unique case (i_ctl.op)
            // capture the transaction, clear per-item results
            via_pkg::OP_LATCH: begin
                n_in = i_item; n_rd = 8'd0; n_hit = 1'b0; n_wrote = 1'b0;
            end

            // register access, line change, port B input
            via_pkg::OP_EXEC: begin
                unique case (r_in.command)
                    via_pkg::CMD_READ: begin
                        unique case (r_in.reg_addr)
                            via_pkg::REG_ORB: begin
                                n_rd = (r_out_b & r_dir_b) | (r_in_b & ~r_dir_b);
                                v_pa_do = 1'b1; v_pa_side = 1'b1;
                            end
                            via_pkg::REG_ORA: begin
                                n_rd = r_out_a & r_dir_a; v_pa_do = 1'b1;
                            end
                            via_pkg::REG_DDRB: n_rd = r_dir_b;
                            via_pkg::REG_DDRA: n_rd = r_dir_a;
                            via_pkg::REG_T1CL: begin
                                n_rd = r_t1_count[7:0];
                                n_ifr = f_clr(r_ifr, via_pkg::IRQ_T1, r_ier);
                            end
                            via_pkg::REG_T1CH: n_rd = r_t1_count[15:8];
                            via_pkg::REG_T1LL: n_rd = r_t1_latch[7:0];
                            via_pkg::REG_T1LH: n_rd = r_t1_latch[15:8];
                            via_pkg::REG_T2CL: begin
                                n_rd = r_t2_count[7:0];
                                n_ifr = f_clr(r_ifr, via_pkg::IRQ_T2, r_ier);
                            end
                            via_pkg::REG_T2CH: n_rd = r_t2_count[15:8];
                            via_pkg::REG_SR: begin
                                n_rd = r_sr;
                                n_ifr = f_clr(r_ifr, via_pkg::IRQ_SR, r_ier);
                            end
                            via_pkg::REG_ACR: n_rd = r_acr;
                            via_pkg::REG_PCR: n_rd = r_pcr;
                            via_pkg::REG_IFR: n_rd = r_ifr;
                            via_pkg::REG_IER: n_rd = {1'b1, r_ier};
                            default:          n_rd = r_out_a & r_dir_a;
                        endcase
                    end
                    via_pkg::CMD_WRITE: begin
                        n_wrote = (r_in.reg_addr == via_pkg::REG_ORB);
                        unique case (r_in.reg_addr)
                            via_pkg::REG_ORB: begin
                                n_out_b = r_in.write_data;
                                v_pa_do = 1'b1; v_pa_side = 1'b1;
                            end
                            via_pkg::REG_ORA: begin
                                n_out_a = r_in.write_data; v_pa_do = 1'b1;
                            end
                            via_pkg::REG_DDRB: n_dir_b = r_in.write_data;
                            via_pkg::REG_DDRA: n_dir_a = r_in.write_data;
                            via_pkg::REG_T1CL, via_pkg::REG_T1LL:
                                n_t1_latch[7:0] = r_in.write_data;
                            via_pkg::REG_T1CH: begin
                                n_t1_latch[15:8] = r_in.write_data;
                                n_t1_count = {r_in.write_data, r_t1_latch[7:0]};
                                n_t1_rld = 1'b1; n_t1_run = 1'b1;
                                n_ifr = f_clr(r_ifr, via_pkg::IRQ_T1, r_ier);
                                if (r_acr[7:6] == 2'b10) n_out_b[7] = 1'b0;
                            end
                            via_pkg::REG_T1LH: begin
                                n_t1_latch[15:8] = r_in.write_data;
                                n_ifr = f_clr(r_ifr, via_pkg::IRQ_T1, r_ier);
                            end
                            via_pkg::REG_T2CL: n_t2_latch[7:0] = r_in.write_data;
                            via_pkg::REG_T2CH: begin
                                n_t2_latch[15:8] = r_in.write_data;
                                n_t2_count = {r_in.write_data, r_t2_latch[7:0]};
                                n_t2_run = 1'b1; n_t2_rld = 1'b1;
                                n_ifr = f_clr(r_ifr, via_pkg::IRQ_T2, r_ier);
                            end
                            via_pkg::REG_SR: begin
                                n_sr = r_in.write_data;
                                n_ifr = f_clr(r_ifr, via_pkg::IRQ_SR, r_ier);
                            end
                            via_pkg::REG_ACR: n_acr = r_in.write_data;
                            via_pkg::REG_PCR: begin
                                n_pcr = r_in.write_data;
                                if (r_in.write_data[3:2] == 2'b11)
                                    n_lines[1] = r_in.write_data[1];
                                if (r_in.write_data[7:6] == 2'b11)
                                    n_lines[3] = r_in.write_data[5];
                            end
                            via_pkg::REG_IFR: begin
                                n_ifr = {1'b0, r_ifr[6:0] & ~r_in.write_data[6:0]};
                                if (|(n_ifr[6:0] & r_ier)) n_ifr[7] = 1'b1;
                            end
                            via_pkg::REG_IER: begin
                                if (r_in.write_data[7])
                                    n_ier = r_ier | r_in.write_data[6:0];
                                else
                                    n_ier = r_ier & ~r_in.write_data[6:0];
                                n_ifr[7] = |(r_ifr[6:0] & n_ier);
                            end
                            default: n_out_a = r_in.write_data;
                        endcase
                    end
                    via_pkg::CMD_LINE: begin
                        v_mode = v_side ? r_pcr[7:5] : r_pcr[3:1];
                        v_pos_edge = v_side ? r_pcr[4] : r_pcr[0];
                        v_sel = v_side ? r_pcr[7:6] : r_pcr[3:2];
                        if (!r_in.line_select[0]) begin
                            // CA1 / CB1: active edge sets flag, may end handshake
                            if (r_lines[{v_side, 1'b0}] != v_lvl) begin
                                n_lines[{v_side, 1'b0}] = v_lvl;
                                if (v_lvl == v_pos_edge) begin
                                    v_mask = v_side ? via_pkg::IRQ_CB1 : via_pkg::IRQ_CA1;
                                    n_ifr = f_set(r_ifr, v_mask, r_ier);
                                    n_hit = |(v_mask[6:0] & r_ier);
                                    if (v_lvl && !r_lines[{v_side, 1'b1}]
                                        && v_mode == 3'b100)
                                        n_lines[{v_side, 1'b1}] = 1'b1;
                                end
                            end
                        end else begin
                            // CA2 / CB2 input edge
                            if (r_lines[{v_side, 1'b1}] != v_lvl) begin
                                n_lines[{v_side, 1'b1}] = v_lvl;
                                if ((v_lvl && v_sel == 2'b01) ||
                                    (!v_lvl && v_sel == 2'b00)) begin
                                    v_mask = v_side ? via_pkg::IRQ_CB2 : via_pkg::IRQ_CA2;
                                    n_ifr = f_set(r_ifr, v_mask, r_ier);
                                    n_hit = |(v_mask[6:0] & r_ier);
                                end
                            end
                        end
                    end
                    via_pkg::CMD_PORTB: n_in_b[r_in.bit_index] = r_in.write_data[0];
                    default: ;
                endcase

                // side effects of an ORA / ORB access
                if (v_pa_do) begin
                    v_mode = v_pa_side ? r_pcr[7:5] : r_pcr[3:1];
                    n_ifr = f_clr(n_ifr, v_pa_side ? via_pkg::IRQ_CB1 : via_pkg::IRQ_CA1,
                                  r_ier);
                    if (v_mode == 3'b000 || v_mode == 3'b010) begin
                        n_ifr = f_clr(n_ifr,
                                      v_pa_side ? via_pkg::IRQ_CB2 : via_pkg::IRQ_CA2,
                                      r_ier);
                    end else if (v_mode == 3'b100) begin
                        n_lines[{v_pa_side, 1'b1}] = 1'b0;
                    end else if (v_mode == 3'b101) begin
                        n_lines[{v_pa_side, 1'b1}] = 1'b0;
                        n_pulse[v_pa_side] = 1'b1;
                    end
                end
            end

            // tick: end pulses, one-shot timer 1 or free-run setup
            via_pkg::OP_TICK: begin
                if (r_in.cycles != 8'd0) begin
                    if (r_pulse[0]) n_lines[1] = 1'b1;
                    if (r_pulse[1]) n_lines[3] = 1'b1;
                    n_pulse = 2'b00;
                    if (!r_acr[6]) begin
                        if (r_t1_run && ({8'd0, r_in.cycles} > r_t1_count)) begin
                            n_ifr = f_set(r_ifr, via_pkg::IRQ_T1, r_ier);
                            n_hit = r_hit | r_ier[6];
                            if (r_acr[7]) n_out_b[7] = 1'b1;
                            n_t1_run = 1'b0;
                        end
                        n_t1_count = r_t1_count - {8'd0, r_in.cycles};
                    end else begin
                        n_todo = r_in.cycles;
                        if (r_t1_rld) begin
                            n_todo = r_in.cycles - 8'd1;
                            n_t1_count = r_t1_latch;
                            n_t1_rld = 1'b0;
                        end
                    end
                end
            end

            // one underflow of free-running timer 1, or the final count down
            via_pkg::OP_T1_STEP: begin
                if (v_t1_over) begin
                    n_ifr = f_set(r_ifr, via_pkg::IRQ_T1, r_ier);
                    n_hit = r_hit | r_ier[6];
                    if (r_acr[7]) n_out_b[7] = ~r_out_b[7];
                    n_t1_count = 16'hffff;
                    n_todo = v_t;
                    if (v_t == 8'd0) begin
                        n_t1_rld = 1'b1;
                    end else begin
                        n_todo = v_t - 8'd1;
                        n_t1_count = r_t1_latch;
                    end
                end else begin
                    n_t1_count = r_t1_count - {8'd0, r_todo};
                end
            end

            // timer 2 one-shot
            via_pkg::OP_T2: begin
                if (r_in.cycles != 8'd0 && !r_acr[5]) begin
                    v_t2_todo = r_in.cycles - {7'd0, r_t2_rld};
                    n_t2_rld = 1'b0;
                    if (r_t2_run && ({8'd0, v_t2_todo} > r_t2_count)) begin
                        n_ifr = f_set(r_ifr, via_pkg::IRQ_T2, r_ier);
                        n_hit = r_hit | r_ier[5];
                        n_t2_run = 1'b0;
                    end
                    n_t2_count = r_t2_count - {8'd0, v_t2_todo};
                end
            end

            default: ;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_todo <= n_todo;
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_a <= '0; r_out_b <= '0; r_dir_a <= '0; r_dir_b <= '0; r_in_b <= '0;
            r_t1_latch <= '0; r_t1_count <= '0; r_t1_run <= 1'b0; r_t1_rld <= 1'b0;
            r_t2_latch <= '0; r_t2_count <= '0; r_t2_run <= 1'b0; r_t2_rld <= 1'b0;
            r_sr <= '0; r_acr <= '0; r_pcr <= '0; r_ifr <= '0; r_ier <= '0;
            r_lines <= '0; r_pulse <= '0;
            r_rd <= '0; r_hit <= 1'b0; r_wrote <= 1'b0;
        end else begin
            r_out_a <= n_out_a; r_out_b <= n_out_b; r_dir_a <= n_dir_a;
            r_dir_b <= n_dir_b; r_in_b <= n_in_b;
            r_t1_latch <= n_t1_latch; r_t1_count <= n_t1_count;
            r_t1_run <= n_t1_run; r_t1_rld <= n_t1_rld;
            r_t2_latch <= n_t2_latch; r_t2_count <= n_t2_count;
            r_t2_run <= n_t2_run; r_t2_rld <= n_t2_rld;
            r_sr <= n_sr; r_acr <= n_acr; r_pcr <= n_pcr; r_ifr <= n_ifr;
            r_ier <= n_ier; r_lines <= n_lines; r_pulse <= n_pulse;
            r_rd <= n_rd; r_hit <= n_hit; r_wrote <= n_wrote;
        end
    end

    // result
    assign o_result.read_data      = r_rd;
    assign o_result.irq_request    = r_hit;
    assign o_result.irq_pending    = r_ifr[7];
    assign o_result.ca2_level      = r_lines[1];
    assign o_result.cb2_level      = r_lines[3];
    assign o_result.port_a_out     = r_out_a;
    assign o_result.port_b_out     = r_out_b;
    assign o_result.port_b_written = r_wrote;

`ifndef SYNTHESIS
    // bit 7 of IFR always mirrors the enabled flags
    a_ifr7: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ifr[7] == |(r_ifr[6:0] & r_ier))
        else $error("IFR bit 7 out of step with enabled flags");
    // a raised request implies a pending interrupt
    a_hit_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> r_ifr[7])
        else $error("irq request without pending interrupt");
    // timer 1 loop hands over to timer 2 once no work is left
    a_t1_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == via_pkg::OP_T1_STEP && !o_sts.t1_more)
        |=> (i_ctl.op == via_pkg::OP_T2))
        else $error("timer 1 loop did not terminate");
`endif

endmodule

>>> src/versatile_interface_adapter.sv
// ============================================================================
// versatile_interface_adapter
// 6522-style interface adapter: ports, timers, control lines, interrupts.
// ============================================================================
// A transaction is taken when start is high and busy is low; one result per
// transaction appears on o_result for one cycle with o_strobe, and the
// receiver has no way to hold it off. Reads, writes, line changes and port B
// input bits go through the execute and done states and raise the strobe in
// the done state. A tick with timer 1 in one-shot mode goes through the tick,
// timer 2 and done states. With timer 1 free-running, the controller walks
// the underflows one at a time through the timer 1 step logic: one step per
// underflow plus one for the final count down, which is left out when the
// tick ends exactly on an underflow; at worst (latch of zero, cycles field of
// 255) that is 128 steps. Start is taken again in the cycle after the strobe.
module versatile_interface_adapter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  via_pkg::t_in_item   i_item,
    output logic                busy,
    output logic                o_strobe,
    output via_pkg::t_out_item  o_result
);

    via_pkg::t_ctl w_ctl;
    via_pkg::t_sts w_sts;

    // sequencer
    via_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_item.command),
        .i_sts     (w_sts),
        .o_ctl     (w_ctl),
        .busy      (busy),
        .o_strobe  (o_strobe)
    );

    // registers and timers
    via_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (w_ctl),
        .o_sts    (w_sts),
        .o_result (o_result)
    );

endmodule
